// ===== rtl/clle_pkg.sv =====
// ----------------------------------------------------------------------------
// clle_pkg
// Shared types, constants and helpers for the cursor linked list engine:
// pool size, pointer widths, command codes, sequencer states and words.
// ----------------------------------------------------------------------------
package clle_pkg;

  localparam int NODE_COUNT = 256;
  localparam int ADDR_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int PTR_W      = $clog2(NODE_COUNT + 1);
  localparam int VALUE_W    = 32;
  localparam int CMD_W      = 4;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NODE_COUNT);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR        = 4'd0,
    CMD_INSERT_HEAD  = 4'd1,
    CMD_CURSOR_HEAD  = 4'd2,
    CMD_READ_HEAD    = 4'd3,
    CMD_DELETE_HEAD  = 4'd4,
    CMD_DELETE_AFTER = 4'd5,
    CMD_INSERT_AFTER = 4'd6,
    CMD_READ_CURSOR  = 4'd7,
    CMD_UPDATE       = 4'd8,
    CMD_ADVANCE      = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SECOND,
    ST_LINK
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic                      error;
    logic                      cursor_active;
  } out_word_t;

  // One port per memory: a read or a write at one address each cycle
  typedef struct packed {
    logic               link_we;
    logic               link_re;
    logic [ADDR_W-1:0]  link_addr;
    logic [PTR_W-1:0]   link_wdata;
    logic               val_we;
    logic               val_re;
    logic [ADDR_W-1:0]  val_addr;
    logic [VALUE_W-1:0] val_wdata;
  } mem_req_t;

  function automatic logic is_node(input logic [PTR_W-1:0] p);
    return p < NULL_PTR;
  endfunction

  function automatic logic [ADDR_W-1:0] node_addr(input logic [PTR_W-1:0] p);
    return ADDR_W'(p);
  endfunction

endpackage

// ===== rtl/clle_store.sv =====
// ----------------------------------------------------------------------------
// clle_store
// Node pool storage: value memory and next-pointer memory, each a single
// port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module clle_store
  import clle_pkg::*;
(
  input  logic               clk,
  input  mem_req_t           req,
  output logic [PTR_W-1:0]   link_q,
  output logic [VALUE_W-1:0] value_q
);

  logic [PTR_W-1:0]   link_mem  [NODE_COUNT];
  logic [VALUE_W-1:0] value_mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_addr] <= req.link_wdata;
    end else if (req.link_re) begin
      link_q <= link_mem[req.link_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.val_we) begin
      value_mem[req.val_addr] <= req.val_wdata;
    end else if (req.val_re) begin
      value_q <= value_mem[req.val_addr];
    end
  end

endmodule

// ===== rtl/cursor_linked_list_engine_unit.sv =====
// Sequence: a word is taken in idle, where its first read is issued, and
//   for most commands its result is registered in the first state; delete
//   after and insert after from the free list, when they act, go on through
//   the second and link states, insert after from fresh nodes to link only.
// Input: in_stall is high outside idle; a new word waits for the last one.
// Reset: head, cursor and free list go null, fresh count to zero; node
//   memories are not cleared and the block is ready at once.
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_unit
// Singly linked list with a cursor over a bounded node pool, with a free
// list and a fresh-node counter; a small sequencer drives the node memories.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_unit
  import clle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  state_t                    state_r, state_nxt;
  logic [CMD_W-1:0]          cmd_r, cmd_nxt;
  logic [VALUE_W-1:0]        val_r, val_nxt;
  logic [PTR_W-1:0]          head_r, head_nxt;
  logic [PTR_W-1:0]          cur_r, cur_nxt;
  logic [PTR_W-1:0]          free_r, free_nxt;
  logic [PTR_W-1:0]          fresh_r, fresh_nxt;
  logic [PTR_W-1:0]          n_r, n_nxt;
  logic [PTR_W-1:0]          nx_r, nx_nxt;
  logic                      out_valid_r;
  out_word_t                 out_word_r;

  mem_req_t                  req;
  logic [PTR_W-1:0]          link_q;
  logic [VALUE_W-1:0]        value_q;
  logic                      out_free;
  logic                      done;
  logic [VALUE_W-1:0]        rd;
  logic                      err;

  clle_store u_store (
    .clk     (clk),
    .req     (req),
    .link_q  (link_q),
    .value_q (value_q)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= NULL_PTR;
      cur_r       <= NULL_PTR;
      free_r      <= NULL_PTR;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cur_r   <= cur_nxt;
      free_r  <= free_nxt;
      fresh_r <= fresh_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
    n_r   <= n_nxt;
    nx_r  <= nx_nxt;
    if (done) begin
      out_word_r.read_value    <= $signed(rd);
      out_word_r.error         <= err;
      out_word_r.cursor_active <= is_node(cur_nxt);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;
    head_nxt  = head_r;
    cur_nxt   = cur_r;
    free_nxt  = free_r;
    fresh_nxt = fresh_r;
    n_nxt     = n_r;
    nx_nxt    = nx_r;
    req       = '0;
    done      = 1'b0;
    rd        = '0;
    err       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_word.command;
          val_nxt   = in_word.item_value;
          state_nxt = ST_FIRST;
          // issue the first read from the incoming command
          unique case (in_word.command)
            CMD_INSERT_HEAD: begin
              req.link_re   = is_node(free_r);
              req.link_addr = node_addr(free_r);
            end
            CMD_READ_HEAD: begin
              req.val_re   = is_node(head_r);
              req.val_addr = node_addr(head_r);
            end
            CMD_DELETE_HEAD: begin
              req.link_re   = is_node(head_r);
              req.link_addr = node_addr(head_r);
            end
            CMD_DELETE_AFTER, CMD_INSERT_AFTER, CMD_ADVANCE: begin
              req.link_re   = is_node(cur_r);
              req.link_addr = node_addr(cur_r);
            end
            CMD_READ_CURSOR: begin
              req.val_re   = is_node(cur_r);
              req.val_addr = node_addr(cur_r);
            end
            default: ;
          endcase
        end
      end

      ST_FIRST: begin
        // hold here until the output slot is free
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
          unique case (cmd_r)
            CMD_CLEAR: begin
              head_nxt  = NULL_PTR;
              cur_nxt   = NULL_PTR;
              free_nxt  = NULL_PTR;
              fresh_nxt = '0;
            end
            CMD_INSERT_HEAD: begin
              priority if (is_node(free_r)) begin
                n_nxt    = free_r;
                free_nxt = link_q;
              end else if (fresh_r < NULL_PTR) begin
                n_nxt     = fresh_r;
                fresh_nxt = fresh_r + PTR_W'(1);
              end else begin
                n_nxt = NULL_PTR;
                err   = 1'b1;
              end
              if (!err) begin
                req.val_we     = 1'b1;
                req.val_addr   = node_addr(n_nxt);
                req.val_wdata  = val_r;
                req.link_we    = 1'b1;
                req.link_addr  = node_addr(n_nxt);
                req.link_wdata = head_r;
                head_nxt       = n_nxt;
              end
            end
            CMD_CURSOR_HEAD: begin
              cur_nxt = head_r;
            end
            CMD_READ_HEAD: begin
              if (is_node(head_r)) begin
                rd = value_q;
              end else begin
                err = 1'b1;
              end
            end
            CMD_DELETE_HEAD: begin
              if (is_node(head_r)) begin
                if (cur_r == head_r) begin
                  cur_nxt = NULL_PTR;
                end
                head_nxt       = link_q;
                req.link_we    = 1'b1;
                req.link_addr  = node_addr(head_r);
                req.link_wdata = free_r;
                free_nxt       = head_r;
              end
            end
            CMD_DELETE_AFTER: begin
              if (is_node(cur_r) && is_node(link_q)) begin
                done          = 1'b0;
                n_nxt         = link_q;
                req.link_re   = 1'b1;
                req.link_addr = node_addr(link_q);
                state_nxt     = ST_SECOND;
              end
            end
            CMD_INSERT_AFTER: begin
              if (is_node(cur_r)) begin
                nx_nxt = link_q;
                priority if (is_node(free_r)) begin
                  done          = 1'b0;
                  req.link_re   = 1'b1;
                  req.link_addr = node_addr(free_r);
                  state_nxt     = ST_SECOND;
                end else if (fresh_r < NULL_PTR) begin
                  done           = 1'b0;
                  n_nxt          = fresh_r;
                  fresh_nxt      = fresh_r + PTR_W'(1);
                  req.val_we     = 1'b1;
                  req.val_addr   = node_addr(fresh_r);
                  req.val_wdata  = val_r;
                  req.link_we    = 1'b1;
                  req.link_addr  = node_addr(fresh_r);
                  req.link_wdata = link_q;
                  state_nxt      = ST_LINK;
                end else begin
                  err = 1'b1;
                end
              end
            end
            CMD_READ_CURSOR: begin
              if (is_node(cur_r)) begin
                rd = value_q;
              end else begin
                err = 1'b1;
              end
            end
            CMD_UPDATE: begin
              if (is_node(cur_r)) begin
                req.val_we    = 1'b1;
                req.val_addr  = node_addr(cur_r);
                req.val_wdata = val_r;
              end
            end
            CMD_ADVANCE: begin
              if (is_node(cur_r)) begin
                cur_nxt = link_q;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SECOND: begin
        state_nxt = ST_LINK;
        unique case (cmd_r)
          CMD_DELETE_AFTER: begin
            // unlink the victim: cursor now skips to its successor
            req.link_we    = 1'b1;
            req.link_addr  = node_addr(cur_r);
            req.link_wdata = link_q;
          end
          CMD_INSERT_AFTER: begin
            n_nxt          = free_r;
            free_nxt       = link_q;
            req.val_we     = 1'b1;
            req.val_addr   = node_addr(free_r);
            req.val_wdata  = val_r;
            req.link_we    = 1'b1;
            req.link_addr  = node_addr(free_r);
            req.link_wdata = nx_r;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_LINK: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
          unique case (cmd_r)
            CMD_DELETE_AFTER: begin
              req.link_we    = 1'b1;
              req.link_addr  = node_addr(n_r);
              req.link_wdata = free_r;
              free_nxt       = n_r;
            end
            CMD_INSERT_AFTER: begin
              req.link_we    = 1'b1;
              req.link_addr  = node_addr(cur_r);
              req.link_wdata = n_r;
            end
            default: ;
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_to_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_FIRST))
    else $error("accepted word did not start the sequence");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= NULL_PTR)
    else $error("fresh count beyond pool size");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.link_we && req.link_re) && !(req.val_we && req.val_re))
    else $error("read and write on one memory port in the same cycle");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) != ST_IDLE))
    else $error("result raised without a word in progress");

  a_ready_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !in_stall)
    else $error("sequencer did not return to idle after a result");

endmodule

// ===== tb/sv/cursor_linked_list_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_unit_tb
// Self-checking bench for the cursor linked list engine. A scoreboard keeps
// its own copy of the node pool, head, cursor and free list, predicts every
// result word and checks the block's output in order. Stimulus runs a short
// directed pass over the edge cases, then random command mixes that grow,
// fill and drain the list under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_unit_tb
  import clle_pkg::*;
();

  localparam logic [CMD_W-1:0] NOP_FIRST = 4'd10;
  localparam logic [CMD_W-1:0] NOP_LAST  = 4'd15;
  localparam int IDLE_LIMIT  = 1000;
  localparam int HOLD_START  = 300;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_REPORTS = 30;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

  class list_scoreboard;
    logic [VALUE_W-1:0] node_value [NODE_COUNT];
    logic [PTR_W-1:0]   node_link  [NODE_COUNT];
    logic [PTR_W-1:0]   head;
    logic [PTR_W-1:0]   cursor;
    logic [PTR_W-1:0]   free_top;
    logic [PTR_W-1:0]   fresh;
    out_word_t          expected_q [$];
    int                 fail_count;
    int                 match_count;
    int                 error_count;
    int                 cmd_seen [16];

    function new();
      head = NULL_PTR;
      cursor = NULL_PTR;
      free_top = NULL_PTR;
      fresh = '0;
      fail_count = 0;
      match_count = 0;
      error_count = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    function logic [PTR_W-1:0] next_of(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] v;
      if (p >= NULL_PTR) return NULL_PTR;
      v = node_link[p];
      return (v < NULL_PTR) ? v : NULL_PTR;
    endfunction

    // free list first, then never-used nodes
    function logic [PTR_W-1:0] alloc_node();
      logic [PTR_W-1:0] n;
      if (free_top < NULL_PTR) begin
        n = free_top;
        free_top = next_of(n);
      end else if (fresh < NODE_COUNT) begin
        n = fresh;
        fresh = fresh + 1'b1;
      end else begin
        n = NULL_PTR;
      end
      return n;
    endfunction

    function void release_node(input logic [PTR_W-1:0] n);
      node_link[n] = free_top;
      free_top = n;
    endfunction

    function void note_input(input in_word_t w);
      out_word_t        e;
      logic [PTR_W-1:0] n;
      e = '0;
      cmd_seen[w.command]++;
      case (w.command)
        CMD_CLEAR: begin
          head = NULL_PTR;
          cursor = NULL_PTR;
          free_top = NULL_PTR;
          fresh = '0;
        end
        CMD_INSERT_HEAD: begin
          n = alloc_node();
          if (n == NULL_PTR) begin
            e.error = 1'b1;
          end else begin
            node_value[n] = w.item_value;
            node_link[n] = head;
            head = n;
          end
        end
        CMD_CURSOR_HEAD: cursor = head;
        CMD_READ_HEAD: begin
          if (head < NULL_PTR) e.read_value = node_value[head];
          else e.error = 1'b1;
        end
        CMD_DELETE_HEAD: begin
          if (head < NULL_PTR) begin
            n = head;
            if (cursor == n) cursor = NULL_PTR;
            head = next_of(n);
            release_node(n);
          end
        end
        CMD_DELETE_AFTER: begin
          if (cursor < NULL_PTR) begin
            n = next_of(cursor);
            if (n < NULL_PTR) begin
              node_link[cursor] = next_of(n);
              release_node(n);
            end
          end
        end
        CMD_INSERT_AFTER: begin
          if (cursor < NULL_PTR) begin
            n = alloc_node();
            if (n == NULL_PTR) begin
              e.error = 1'b1;
            end else begin
              node_value[n] = w.item_value;
              node_link[n] = next_of(cursor);
              node_link[cursor] = n;
            end
          end
        end
        CMD_READ_CURSOR: begin
          if (cursor < NULL_PTR) e.read_value = node_value[cursor];
          else e.error = 1'b1;
        end
        CMD_UPDATE: if (cursor < NULL_PTR) node_value[cursor] = w.item_value;
        CMD_ADVANCE: if (cursor < NULL_PTR) cursor = next_of(cursor);
        default: ;
      endcase
      e.cursor_active = (cursor < NULL_PTR);
      if (e.error) error_count++;
      expected_q.push_back(e);
    endfunction

    function void report(input string field, input logic [VALUE_W-1:0] exp_v,
                         input logic [VALUE_W-1:0] got_v);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
    endfunction

    function void check_result(input out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      if (got.read_value !== e.read_value) report("read_value", e.read_value, got.read_value);
      if (got.error !== e.error) report("error", VALUE_W'(e.error), VALUE_W'(got.error));
      if (got.cursor_active !== e.cursor_active)
        report("cursor_active", VALUE_W'(e.cursor_active), VALUE_W'(got.cursor_active));
      if (got === e) match_count++;
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  list_scoreboard sb = new();
  int             burst_left = 0;
  int             sent_count = 0;

  cursor_linked_list_engine_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // check the result first: it always belongs to an earlier word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_word);
      if (in_valid && !in_stall) sb.note_input(in_word);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: segments of stall patterns, plus one long hold to back up the input
  initial begin
    int cyc;
    int seg_left;
    int mode;
    int hold_left;
    cyc = 0;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 80);
        end
        seg_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= (cyc % 3 == 0);
          default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    in_word <= '{command: cmd, item_value: val};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return CMD_W'($urandom_range(NOP_FIRST, NOP_LAST));
    case (mix)
      MIX_FILL: begin
        if (r < 50) return CMD_INSERT_HEAD;
        if (r < 90) return CMD_INSERT_AFTER;
        if (r < 93) return CMD_CURSOR_HEAD;
        if (r < 96) return CMD_ADVANCE;
        if (r < 98) return CMD_READ_CURSOR;
        return CMD_READ_HEAD;
      end
      MIX_DRAIN: begin
        if (r < 35) return CMD_DELETE_HEAD;
        if (r < 58) return CMD_DELETE_AFTER;
        if (r < 68) return CMD_CURSOR_HEAD;
        if (r < 78) return CMD_ADVANCE;
        if (r < 84) return CMD_READ_HEAD;
        if (r < 89) return CMD_READ_CURSOR;
        if (r < 94) return CMD_UPDATE;
        return CMD_INSERT_HEAD;
      end
      default: begin
        if (r < 5) return CMD_CLEAR;
        if (r < 18) return CMD_INSERT_HEAD;
        if (r < 31) return CMD_INSERT_AFTER;
        if (r < 39) return CMD_CURSOR_HEAD;
        if (r < 46) return CMD_READ_HEAD;
        if (r < 55) return CMD_DELETE_HEAD;
        if (r < 64) return CMD_DELETE_AFTER;
        if (r < 73) return CMD_READ_CURSOR;
        if (r < 81) return CMD_UPDATE;
        return CMD_ADVANCE;
      end
    endcase
  endfunction

  task automatic run_mix(input mix_t mix, input int count);
    repeat (count) send_word(pick_command(mix), $urandom());
  endtask

  initial begin
    int codes_hit;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list and inactive cursor
    send_word(CMD_READ_HEAD, 32'h0);
    send_word(CMD_READ_CURSOR, 32'h0);
    send_word(CMD_DELETE_HEAD, 32'h0);
    send_word(CMD_ADVANCE, 32'h0);
    send_word(CMD_UPDATE, 32'h1234_5678);
    send_word(CMD_INSERT_AFTER, 32'hDEAD_BEEF);
    send_word(CMD_DELETE_AFTER, 32'h0);
    // value extremes
    send_word(CMD_INSERT_HEAD, 32'h8000_0000);
    send_word(CMD_INSERT_HEAD, 32'h7FFF_FFFF);
    send_word(CMD_INSERT_HEAD, 32'h0000_0000);
    send_word(CMD_CURSOR_HEAD, 32'h0);
    send_word(CMD_READ_HEAD, 32'h0);
    send_word(CMD_READ_CURSOR, 32'h0);
    send_word(CMD_UPDATE, 32'hFFFF_FFFF);
    send_word(CMD_READ_CURSOR, 32'h0);
    send_word(CMD_INSERT_AFTER, 32'h5555_5555);
    // walk to the tail, then try to delete past it
    send_word(CMD_ADVANCE, 32'h0);
    send_word(CMD_READ_CURSOR, 32'h0);
    send_word(CMD_ADVANCE, 32'h0);
    send_word(CMD_ADVANCE, 32'h0);
    send_word(CMD_DELETE_AFTER, 32'h0);
    send_word(CMD_CURSOR_HEAD, 32'h0);
    send_word(CMD_DELETE_AFTER, 32'h0);
    // drop the head under the cursor
    send_word(CMD_DELETE_HEAD, 32'h0);
    send_word(NOP_LAST, 32'hFFFF_FFFF);
    send_word(NOP_FIRST, 32'h0);
    send_word(CMD_CLEAR, 32'h0);

    run_mix(MIX_BALANCED, 120);
    send_word(CMD_CLEAR, 32'h0);
    // grow past the pool size so both insert kinds hit a full pool
    send_word(CMD_INSERT_HEAD, $urandom());
    send_word(CMD_CURSOR_HEAD, 32'h0);
    run_mix(MIX_FILL, 300);
    run_mix(MIX_DRAIN, 60);
    run_mix(MIX_BALANCED, 50);
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    codes_hit = 0;
    foreach (sb.cmd_seen[i]) if (sb.cmd_seen[i] != 0) codes_hit++;
    $display("Sent %0d words covering %0d of 16 command codes; %0d results matched.",
             sent_count, codes_hit, sb.match_count);
    $display("Error flag expected %0d times, including reads of empty state and full pool.",
             sb.error_count);
    if (sb.fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/clle_pkg.sv
rtl/clle_store.sv
rtl/cursor_linked_list_engine_unit.sv
tb/sv/cursor_linked_list_engine_unit_tb.sv
